@@ rtl/calu_pkg.sv @@
// package: operation codes, flag and result types for the 8-bit cpu alu
`timescale 1ns / 1ps
package calu_pkg;

	localparam int unsigned FuncWidth = 4;
	localparam int unsigned DataWidth = 16;
	localparam int unsigned ByteWidth = 8;

	typedef enum logic [FuncWidth-1:0] {
		OP_ADD   = 4'd0,
		OP_ADC   = 4'd1,
		OP_SUB   = 4'd2,
		OP_SBC   = 4'd3,
		OP_AND   = 4'd4,
		OP_XOR   = 4'd5,
		OP_OR    = 4'd6,
		OP_CP    = 4'd7,
		OP_INC   = 4'd8,
		OP_DEC   = 4'd9,
		OP_DAA   = 4'd10,
		OP_CPL   = 4'd11,
		OP_SCF   = 4'd12,
		OP_CCF   = 4'd13,
		OP_ADD16 = 4'd14
	} alu_op_t;

	typedef struct packed {
		logic z;
		logic n;
		logic h;
		logic c;
	} flags_t;

	typedef struct packed {
		logic [DataWidth-1:0] value;
		logic                 wr;
		flags_t               flags;
	} alu_res_t;

	localparam logic [ByteWidth-1:0] DaaHiAdj  = 8'h60;
	localparam logic [ByteWidth-1:0] DaaLoAdj  = 8'h06;
	localparam logic [ByteWidth-1:0] DaaHiMax  = 8'h99;
	localparam logic [3:0]           DaaLoMax  = 4'h9;
	localparam logic [ByteWidth-1:0] ByteOnes  = 8'hff;

endpackage

@@ rtl/calu_core.sv @@
// combinational datapath: value and flags for one operation
`timescale 1ns / 1ps
module calu_core (
	input  calu_pkg::alu_op_t         func,
	input  logic [15:0]               operand_a,
	input  logic [15:0]               operand_b,
	input  calu_pkg::flags_t          flags_in,
	output calu_pkg::alu_res_t        res
);
	import calu_pkg::*;

	logic [7:0]  a8;
	logic [7:0]  b8;
	logic        cin;
	logic [8:0]  sum9;
	logic [4:0]  hsum5;
	logic [8:0]  diff9;
	logic [4:0]  hdiff5;
	logic [7:0]  inc8;
	logic [7:0]  dec8;
	logic [7:0]  daa8;
	logic        daa_c;
	logic [7:0]  and8;
	logic [7:0]  xor8;
	logic [7:0]  or8;
	logic [16:0] sum17;
	logic [12:0] hsum13;

	assign a8  = operand_a[7:0];
	assign b8  = operand_b[7:0];
	assign cin = ((func == OP_ADC) || (func == OP_SBC)) ? flags_in.c : 1'b0;

	assign sum9   = {1'b0, a8} + {1'b0, b8} + {8'd0, cin};
	assign hsum5  = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, cin};
	assign diff9  = {1'b0, a8} - {1'b0, b8} - {8'd0, cin};
	assign hdiff5 = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, cin};
	assign inc8   = a8 + 8'd1;
	assign dec8   = a8 - 8'd1;
	assign and8   = a8 & b8;
	assign xor8   = a8 ^ b8;
	assign or8    = a8 | b8;
	assign sum17  = {1'b0, operand_a} + {1'b0, operand_b};
	assign hsum13 = {1'b0, operand_a[11:0]} + {1'b0, operand_b[11:0]};

	// decimal adjust
	always_comb begin
		daa8  = a8;
		daa_c = flags_in.c;
		if (flags_in.n) begin
			daa8 = a8 - (flags_in.c ? DaaHiAdj : 8'd0) - (flags_in.h ? DaaLoAdj : 8'd0);
		end else begin
			if (flags_in.c || (a8 > DaaHiMax)) begin
				daa_c = 1'b1;
			end
			daa8 = a8 + (daa_c ? DaaHiAdj : 8'd0)
				+ ((flags_in.h || (a8[3:0] > DaaLoMax)) ? DaaLoAdj : 8'd0);
		end
	end

	always_comb begin
		res.value   = '0;
		res.wr      = 1'b0;
		res.flags   = flags_in;
		unique case (func)
			OP_ADD, OP_ADC: begin
				res.value = {8'd0, sum9[7:0]};
				res.wr    = 1'b1;
				res.flags = '{z: (sum9[7:0] == 8'd0), n: 1'b0, h: hsum5[4], c: sum9[8]};
			end
			OP_SUB, OP_SBC, OP_CP: begin
				res.value = {8'd0, diff9[7:0]};
				res.wr    = (func != OP_CP);
				res.flags = '{z: (diff9[7:0] == 8'd0), n: 1'b1, h: hdiff5[4], c: diff9[8]};
			end
			OP_AND: begin
				res.value = {8'd0, and8};
				res.wr    = 1'b1;
				res.flags = '{z: (and8 == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
			end
			OP_XOR: begin
				res.value = {8'd0, xor8};
				res.wr    = 1'b1;
				res.flags = '{z: (xor8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
			end
			OP_OR: begin
				res.value = {8'd0, or8};
				res.wr    = 1'b1;
				res.flags = '{z: (or8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
			end
			OP_INC: begin
				res.value = {8'd0, inc8};
				res.wr    = 1'b1;
				res.flags = '{z: (inc8 == 8'd0), n: 1'b0, h: (a8[3:0] == 4'hf),
					c: flags_in.c};
			end
			OP_DEC: begin
				res.value = {8'd0, dec8};
				res.wr    = 1'b1;
				res.flags = '{z: (dec8 == 8'd0), n: 1'b1, h: (a8[3:0] == 4'h0),
					c: flags_in.c};
			end
			OP_DAA: begin
				res.value = {8'd0, daa8};
				res.wr    = 1'b1;
				res.flags = '{z: (daa8 == 8'd0), n: flags_in.n, h: 1'b0, c: daa_c};
			end
			OP_CPL: begin
				res.value = {8'd0, a8 ^ ByteOnes};
				res.wr    = 1'b1;
				res.flags = '{z: flags_in.z, n: 1'b1, h: 1'b1, c: flags_in.c};
			end
			OP_SCF: begin
				res.flags = '{z: flags_in.z, n: 1'b0, h: 1'b0, c: 1'b1};
			end
			OP_CCF: begin
				res.flags = '{z: flags_in.z, n: 1'b0, h: 1'b0, c: ~flags_in.c};
			end
			OP_ADD16: begin
				res.value = sum17[15:0];
				res.wr    = 1'b1;
				res.flags = '{z: flags_in.z, n: 1'b0, h: hsum13[12], c: sum17[16]};
			end
			default: begin
				res.value = '0;
				res.wr    = 1'b0;
				res.flags = flags_in;
			end
		endcase
	end

endmodule

@@ rtl/cpu_alu_8bit_with_flags.sv @@
// top level: input register, alu datapath, result register
//
// channel  direction  handshake             payload
// command  in         start, busy           func, operand_a, operand_b, *_in flags
// result   out        done (one-cycle beat) result_value, write_result, *_out flags
//
// a beat is taken at every edge with start high; busy stays low
// the command beat passes the input register and then the result register; the result shows for one cycle
// one operation per cycle, set by the single datapath pass between the registers
// reset clears the valid bits only; the result side cannot stall
`timescale 1ns / 1ps
module cpu_alu_8bit_with_flags (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [3:0]  func,
	input  logic [15:0] operand_a,
	input  logic [15:0] operand_b,
	input  logic        zero_in,
	input  logic        subtract_in,
	input  logic        half_in,
	input  logic        carry_in,
	output logic        done,
	output logic [15:0] result_value,
	output logic        write_result,
	output logic        zero_out,
	output logic        subtract_out,
	output logic        half_out,
	output logic        carry_out
);
	import calu_pkg::*;

	logic        valid_s1;
	alu_op_t     func_s1;
	logic [15:0] a_s1;
	logic [15:0] b_s1;
	flags_t      flags_s1;
	alu_res_t    res_comb;
	logic        valid_s2;
	alu_res_t    res_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			func_s1  <= alu_op_t'(func);
			a_s1     <= operand_a;
			b_s1     <= operand_b;
			flags_s1 <= '{z: zero_in, n: subtract_in, h: half_in, c: carry_in};
		end
		if (valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	calu_core u_core (
		.func      (func_s1),
		.operand_a (a_s1),
		.operand_b (b_s1),
		.flags_in  (flags_s1),
		.res       (res_comb)
	);

	assign done         = valid_s2;
	assign result_value = res_s2.value;
	assign write_result = res_s2.wr;
	assign zero_out     = res_s2.flags.z;
	assign subtract_out = res_s2.flags.n;
	assign half_out     = res_s2.flags.h;
	assign carry_out    = res_s2.flags.c;

endmodule

@@ rtl/calu_checker.sv @@
// port checker for the alu top level, attached by bind
`timescale 1ns / 1ps
module calu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [3:0]  func,
	input logic        zero_in,
	input logic        done,
	input logic        write_result,
	input logic        zero_out,
	input logic        subtract_out,
	input logic        carry_out
);
	import calu_pkg::*;

	// every command beat gives a result beat, after the input and result registers
	a_beat_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("command beat without result beat");

	// no result beat without a command beat
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> ##1 !done)
		else $error("result beat without command beat");

	a_cp_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(func, 2) == OP_CP) |-> (!write_result && subtract_out))
		else $error("compare wrote its result or cleared n");

	a_scf_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(func, 2) == OP_SCF) |-> (carry_out && !write_result))
		else $error("set carry gave wrong flags");

	a_add16_keeps_z: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(func, 2) == OP_ADD16) |-> (zero_out == $past(zero_in, 2)))
		else $error("16-bit add changed z");

endmodule

bind cpu_alu_8bit_with_flags calu_checker u_calu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.func         (func),
	.zero_in      (zero_in),
	.done         (done),
	.write_result (write_result),
	.zero_out     (zero_out),
	.subtract_out (subtract_out),
	.carry_out    (carry_out)
);

@@ verif/cpu_alu_8bit_with_flags_test.sv @@
// testbench: directed table and random operations for 8-bit cpu alu, checked by table or predictor
`timescale 1ns / 1ps
module cpu_alu_8bit_with_flags_test;
	import calu_pkg::*;

	localparam logic [3:0] OP_NONE = 4'hf;

	typedef struct packed {
		logic [3:0]  func;
		logic [15:0] a;
		logic [15:0] b;
		flags_t      fl;
	} alu_cmd_t;

	typedef struct packed {
		alu_cmd_t cmd;
		logic     typed;
		alu_res_t res;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [3:0]  func;
	logic [15:0] operand_a;
	logic [15:0] operand_b;
	logic        zero_in;
	logic        subtract_in;
	logic        half_in;
	logic        carry_in;
	logic        done;
	logic [15:0] result_value;
	logic        write_result;
	logic        zero_out;
	logic        subtract_out;
	logic        half_out;
	logic        carry_out;

	logic        drv_typed;
	alu_res_t    drv_res;

	alu_res_t    expected_results[$];
	stim_row_t   stim_table[$];
	int unsigned mismatches = 0;

	cpu_alu_8bit_with_flags uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.operand_a(operand_a),
		.operand_b(operand_b),
		.zero_in(zero_in),
		.subtract_in(subtract_in),
		.half_in(half_in),
		.carry_in(carry_in),
		.done(done),
		.result_value(result_value),
		.write_result(write_result),
		.zero_out(zero_out),
		.subtract_out(subtract_out),
		.half_out(half_out),
		.carry_out(carry_out)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic alu_res_t predict_alu(input alu_cmd_t cmd);
		alu_res_t    res;
		logic [7:0]  a;
		logic [7:0]  b;
		logic        cin;
		logic [8:0]  sum;
		logic [4:0]  nib;
		logic [7:0]  r;
		logic [16:0] wide;
		logic [12:0] wide_lo;
		a = cmd.a[7:0];
		b = cmd.b[7:0];
		res.value = '0;
		res.wr = 1'b0;
		res.flags = cmd.fl;
		case (cmd.func)
			OP_ADD, OP_ADC: begin
				cin = (cmd.func == OP_ADC) & cmd.fl.c;
				sum = {1'b0, a} + {1'b0, b} + {8'd0, cin};
				nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
				res.value = {8'h00, sum[7:0]};
				res.wr = 1'b1;
				res.flags = '{z: sum[7:0] == 8'h00, n: 1'b0, h: nib[4], c: sum[8]};
			end
			OP_SUB, OP_SBC, OP_CP: begin
				cin = (cmd.func == OP_SBC) & cmd.fl.c;
				sum = {1'b0, a} - {1'b0, b} - {8'd0, cin};
				nib = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};
				res.value = {8'h00, sum[7:0]};
				res.wr = cmd.func != OP_CP;
				res.flags = '{z: sum[7:0] == 8'h00, n: 1'b1, h: nib[4], c: sum[8]};
			end
			OP_AND, OP_XOR, OP_OR: begin
				r = (cmd.func == OP_AND) ? (a & b) : (cmd.func == OP_XOR) ? (a ^ b) : (a | b);
				res.value = {8'h00, r};
				res.wr = 1'b1;
				res.flags = '{z: r == 8'h00, n: 1'b0, h: cmd.func == OP_AND, c: 1'b0};
			end
			OP_INC: begin
				r = a + 8'd1;
				res.value = {8'h00, r};
				res.wr = 1'b1;
				res.flags = '{z: r == 8'h00, n: 1'b0, h: a[3:0] == 4'hf, c: cmd.fl.c};
			end
			OP_DEC: begin
				r = a - 8'd1;
				res.value = {8'h00, r};
				res.wr = 1'b1;
				res.flags = '{z: r == 8'h00, n: 1'b1, h: a[3:0] == 4'h0, c: cmd.fl.c};
			end
			OP_DAA: begin
				r = a;
				cin = cmd.fl.c;
				if (cmd.fl.n) begin
					if (cmd.fl.c)
						r = r - DaaHiAdj;
					if (cmd.fl.h)
						r = r - DaaLoAdj;
				end else begin
					if (cmd.fl.c || a > DaaHiMax) begin
						r = r + DaaHiAdj;
						cin = 1'b1;
					end
					if (cmd.fl.h || a[3:0] > DaaLoMax)
						r = r + DaaLoAdj;
				end
				res.value = {8'h00, r};
				res.wr = 1'b1;
				res.flags = '{z: r == 8'h00, n: cmd.fl.n, h: 1'b0, c: cin};
			end
			OP_CPL: begin
				res.value = {8'h00, a ^ ByteOnes};
				res.wr = 1'b1;
				res.flags = '{z: cmd.fl.z, n: 1'b1, h: 1'b1, c: cmd.fl.c};
			end
			OP_SCF:
				res.flags = '{z: cmd.fl.z, n: 1'b0, h: 1'b0, c: 1'b1};
			OP_CCF:
				res.flags = '{z: cmd.fl.z, n: 1'b0, h: 1'b0, c: ~cmd.fl.c};
			OP_ADD16: begin
				wide = {1'b0, cmd.a} + {1'b0, cmd.b};
				wide_lo = {1'b0, cmd.a[11:0]} + {1'b0, cmd.b[11:0]};
				res.value = wide[15:0];
				res.wr = 1'b1;
				res.flags = '{z: cmd.fl.z, n: 1'b0, h: wide_lo[12], c: wide[16]};
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic logic [7:0] corner_byte(input int unsigned pick);
		case (pick)
			0: return 8'h00;
			1: return 8'hff;
			2: return 8'h0f;
			3: return 8'hf0;
			4: return 8'h99;
			5: return 8'h9a;
			6: return 8'h80;
			default: return 8'h01;
		endcase
	endfunction

	// alu results come back in command order, after the input and result registers
	always @(posedge clk) begin
		alu_res_t want;
		alu_res_t got;
		if (arst_n) begin
			got = {result_value, write_result, zero_out, subtract_out, half_out, carry_out};
			if (done) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: value %h wr %b znhc %b",
							got.value, got.wr, got.flags);
				end else begin
					want = expected_results.pop_front();
					if (got.value !== want.value || got.wr !== want.wr ||
						got.flags.z !== want.flags.z || got.flags.n !== want.flags.n ||
						got.flags.h !== want.flags.h || got.flags.c !== want.flags.c) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected value %h wr %b znhc %b, got value %h wr %b znhc %b",
								want.value, want.wr, want.flags, got.value, got.wr, got.flags);
					end
				end
			end
			if (start && !busy)
				expected_results.push_back(drv_typed ? drv_res : predict_alu({func, operand_a,
					operand_b, zero_in, subtract_in, half_in, carry_in}));
		end
	end

	task automatic send_cmd(input alu_cmd_t cmd, input logic typed, input alu_res_t res,
		input int unsigned gap);
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		func <= cmd.func;
		operand_a <= cmd.a;
		operand_b <= cmd.b;
		{zero_in, subtract_in, half_in, carry_in} <= cmd.fl;
		drv_typed <= typed;
		drv_res <= res;
		do
			@(posedge clk);
		while (busy !== 1'b0);
	endtask

	task automatic hold_until_drained();
		@(negedge clk);
		start <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		alu_cmd_t    cmd;
		stim_row_t   row;
		bit          no_idle;
		int unsigned gap;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [8:0]  s;
		logic [4:0]  nb;
		logic        sub;
		logic        ci;

		arst_n = 1'b0;
		start = 1'b0;
		func = OP_ADD;
		operand_a = '0;
		operand_b = '0;
		zero_in = 1'b0;
		subtract_in = 1'b0;
		half_in = 1'b0;
		carry_in = 1'b0;
		drv_typed = 1'b0;
		drv_res = '0;
		no_idle = 1'b0;

		// func, a, b, znhc in, typed, value, wr, znhc out
		stim_table.push_back({OP_ADD,   16'habff, 16'hcd01, 4'b0000, 1'b1, 16'h0000, 1'b1, 4'b1011});
		stim_table.push_back({OP_ADC,   16'h000f, 16'h0000, 4'b0001, 1'b1, 16'h0010, 1'b1, 4'b0010});
		stim_table.push_back({OP_SUB,   16'hff00, 16'h0001, 4'b0000, 1'b1, 16'h00ff, 1'b1, 4'b0111});
		stim_table.push_back({OP_SBC,   16'h0010, 16'h770f, 4'b0001, 1'b1, 16'h0000, 1'b1, 4'b1110});
		stim_table.push_back({OP_AND,   16'h12f0, 16'h340f, 4'b0000, 1'b1, 16'h0000, 1'b1, 4'b1010});
		stim_table.push_back({OP_XOR,   16'h00ff, 16'hffff, 4'b1111, 1'b1, 16'h0000, 1'b1, 4'b1000});
		stim_table.push_back({OP_OR,    16'hff00, 16'hff00, 4'b1111, 1'b1, 16'h0000, 1'b1, 4'b1000});
		stim_table.push_back({OP_CP,    16'h0042, 16'h0042, 4'b0000, 1'b1, 16'h0000, 1'b0, 4'b1100});
		stim_table.push_back({OP_INC,   16'h55ff, 16'h0000, 4'b0001, 1'b1, 16'h0000, 1'b1, 4'b1011});
		stim_table.push_back({OP_DEC,   16'h0000, 16'h0000, 4'b1000, 1'b1, 16'h00ff, 1'b1, 4'b0110});
		stim_table.push_back({OP_DAA,   16'h009a, 16'h0000, 4'b0000, 1'b1, 16'h0000, 1'b1, 4'b1001});
		stim_table.push_back({OP_DAA,   16'h0000, 16'h0000, 4'b0111, 1'b1, 16'h009a, 1'b1, 4'b0101});
		stim_table.push_back({OP_CPL,   16'hff00, 16'h0000, 4'b1000, 1'b1, 16'h00ff, 1'b1, 4'b1110});
		stim_table.push_back({OP_SCF,   16'hffff, 16'hffff, 4'b0110, 1'b1, 16'h0000, 1'b0, 4'b0001});
		stim_table.push_back({OP_CCF,   16'hffff, 16'hffff, 4'b1111, 1'b1, 16'h0000, 1'b0, 4'b1000});
		stim_table.push_back({OP_ADD16, 16'hffff, 16'h0001, 4'b0000, 1'b1, 16'h0000, 1'b1, 4'b0011});
		stim_table.push_back({OP_ADD16, 16'h0fff, 16'h0001, 4'b1000, 1'b1, 16'h1000, 1'b1, 4'b1010});
		stim_table.push_back({OP_NONE,  16'hffff, 16'hffff, 4'b1010, 1'b1, 16'h0000, 1'b0, 4'b1010});
		stim_table.push_back({OP_NONE,  16'h1234, 16'h5678, 4'b0101, 1'b1, 16'h0000, 1'b0, 4'b0101});
		stim_table.push_back({OP_ADD,   16'h0008, 16'h0008, 4'b0000, 1'b0, 21'h0});
		stim_table.push_back({OP_ADC,   16'h00ff, 16'hff00, 4'b0001, 1'b0, 21'h0});
		stim_table.push_back({OP_SBC,   16'h0000, 16'h00ff, 4'b0001, 1'b0, 21'h0});
		stim_table.push_back({OP_DAA,   16'h0045, 16'h0000, 4'b0010, 1'b0, 21'h0});
		stim_table.push_back({OP_INC,   16'h000e, 16'h0000, 4'b0000, 1'b0, 21'h0});
		stim_table.push_back({OP_ADD16, 16'h8800, 16'h8800, 4'b0101, 1'b0, 21'h0});

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (stim_table[i]) begin
			row = stim_table[i];
			send_cmd(row.cmd, row.typed, row.res, $urandom_range(0, 15));
		end
		hold_until_drained();

		for (int k = 0; k < 1300; k++) begin
			if ($urandom_range(0, 39) == 0)
				no_idle = ~no_idle;
			cmd.func = ($urandom_range(0, 31) < 30) ? 4'($urandom_range(0, 14)) : OP_NONE;
			cmd.a = 16'($urandom);
			cmd.b = 16'($urandom);
			cmd.fl = 4'($urandom);
			if ($urandom_range(0, 3) == 0)
				cmd.a[7:0] = corner_byte($urandom_range(0, 7));
			if ($urandom_range(0, 3) == 0)
				cmd.b[7:0] = corner_byte($urandom_range(0, 7));
			if (cmd.func == OP_ADD16 && $urandom_range(0, 2) == 0)
				cmd.a = cmd.a | 16'hf800;
			// daa mostly follows a real bcd add or subtract
			if (cmd.func == OP_DAA && $urandom_range(0, 3) != 0) begin
				x = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
				y = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
				sub = 1'($urandom);
				ci = 1'($urandom);
				if (sub) begin
					s = {1'b0, x} - {1'b0, y} - {8'd0, ci};
					nb = {1'b0, x[3:0]} - {1'b0, y[3:0]} - {4'd0, ci};
				end else begin
					s = {1'b0, x} + {1'b0, y} + {8'd0, ci};
					nb = {1'b0, x[3:0]} + {1'b0, y[3:0]} + {4'd0, ci};
				end
				cmd.a[7:0] = s[7:0];
				cmd.fl.n = sub;
				cmd.fl.h = nb[4];
				cmd.fl.c = s[8];
			end
			gap = no_idle ? 0 : $urandom_range(0, 15);
			send_cmd(cmd, 1'b0, '0, gap);
			if (k == 650)
				hold_until_drained();
		end

		hold_until_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/calu_pkg.sv
rtl/calu_core.sv
rtl/cpu_alu_8bit_with_flags.sv
rtl/calu_checker.sv
verif/cpu_alu_8bit_with_flags_test.sv
